// ----- sv/tcw_pkg.sv -----
// Shared types and constants for the text console character writer.
package tcw_pkg;

   localparam int CURSOR_W = 11;
   localparam int CELL_W   = 16;
   localparam int INDEX_W  = 11;

   typedef logic [1:0] action_type;

   localparam action_type ACT_WRITE = 2'd0;
   localparam action_type ACT_SET   = 2'd1;
   localparam action_type ACT_READ  = 2'd2;

   localparam logic [8:0] CODE_NEWLINE   = 9'd10;
   localparam logic [8:0] CODE_BACKSPACE = 9'h100;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   typedef struct packed {
      action_type          action;
      logic [8:0]          char_code;
      logic [3:0]          fore_color;
      logic [3:0]          back_color;
      logic [INDEX_W-1:0]  new_position;
      logic [INDEX_W-1:0]  cell_index;
   } req_payload_type;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_now;
      logic [CELL_W-1:0]   cell_word;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SPACE,
      ST_COPY,
      ST_CLEAR,
      ST_DIVIDE,
      ST_READ,
      ST_REPORT
   } ctrl_state_type;

endpackage

// ----- sv/text_console_char_writer.sv -----
// Write and read: the result is registered after the cell update; finishing waits on a free result register.
// A write that scrolls first copies the rows up through the memory port, then clears the
// last row one cell per cycle. A set finds the column by one row subtraction per cycle.
// After reset the cell memory is swept to zero over COLUMNS*ROWS_STORED cells (2000 by
// default), with req_ready low; the cursor resets to zero.
module text_console_char_writer #(
   parameter int COLUMNS     = 80,
   parameter int ROWS_USED   = 24,
   parameter int ROWS_STORED = 25
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tcw_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tcw_pkg::rsp_payload_type rsp_data
);
   import tcw_pkg::*;

   localparam int CELL_COUNT = COLUMNS * ROWS_STORED;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   logic              out_free;
   logic              done;
   rsp_payload_type   result;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CELL_W-1:0] rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   tcw_ctrl #(
      .COLUMNS     (COLUMNS),
      .ROWS_USED   (ROWS_USED),
      .ROWS_STORED (ROWS_STORED),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_free  (out_free),
      .done      (done),
      .result    (result),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   tcw_cell_ram #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (ADDR_W)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result register: the sequencer may finish a new item as the held one leaves.
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = done || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = done ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/tcw_cell_ram.sv -----
// Screen cell memory: one write port, one registered read port.
module tcw_cell_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [tcw_pkg::CELL_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [tcw_pkg::CELL_W-1:0] rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem_ff [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/tcw_ctrl.sv -----
// Console sequencer: cursor tracking, cell updates, scroll and clear sweeps.
module tcw_ctrl #(
   parameter int COLUMNS     = 80,
   parameter int ROWS_USED   = 24,
   parameter int ROWS_STORED = 25,
   parameter int ADDR_W      = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tcw_pkg::req_payload_type   req_data,
   input  logic                       out_free,
   output logic                       done,
   output tcw_pkg::rsp_payload_type   result,
   output logic                       wr_en,
   output logic [ADDR_W-1:0]          wr_addr,
   output logic [tcw_pkg::CELL_W-1:0] wr_data,
   output logic                       rd_en,
   output logic [ADDR_W-1:0]          rd_addr,
   input  logic [tcw_pkg::CELL_W-1:0] rd_data
);
   import tcw_pkg::*;

   localparam int CELL_COUNT = COLUMNS * ROWS_STORED;
   localparam int USED_CELLS = COLUMNS * ROWS_USED;
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int WIDE_W     = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

   localparam logic [ADDR_W-1:0] LAST_CELL_A = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] USED_A      = ADDR_W'(USED_CELLS);
   localparam logic [ADDR_W-1:0] LAST_USED_A = ADDR_W'(USED_CELLS - 1);
   localparam logic [ADDR_W-1:0] COLUMNS_A   = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] SCROLL_A    = ADDR_W'(USED_CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] COPY_BACK_A = ADDR_W'(COLUMNS + 1);
   localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
   localparam logic [WIDE_W-1:0] CELL_COUNT_W = WIDE_W'(CELL_COUNT);
   localparam logic [WIDE_W-1:0] USED_W       = WIDE_W'(USED_CELLS);

   ctrl_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [7:0]        attr_ff, attr_in;
   logic              copy_wr_ff, copy_wr_in;
   logic              rd_ok_ff, rd_ok_in;

   logic [7:0]        req_attr;
   logic [ADDR_W-1:0] step_pos;
   logic [COL_W-1:0]  step_col;
   logic              plain_char;
   logic [WIDE_W-1:0] set_wide;
   logic [WIDE_W-1:0] idx_wide;
   logic [ADDR_W-1:0] set_pos;
   logic              idx_ok;

   // Cursor movement of a write action, before any scroll; clamped set position and read index check.
   always_comb begin
      req_attr   = {req_data.back_color, req_data.fore_color};
      plain_char = 1'b0;
      step_pos   = pos_ff;
      step_col   = col_ff;
      if (req_data.char_code == CODE_NEWLINE) begin
         step_pos = pos_ff + COLUMNS_A - ADDR_W'(col_ff);
         step_col = '0;
      end else if (req_data.char_code == CODE_BACKSPACE) begin
         if (pos_ff != '0) begin
            step_pos = pos_ff - ADDR_W'(1);
            step_col = (col_ff == '0) ? LAST_COL : col_ff - COL_W'(1);
         end
      end else begin
         plain_char = 1'b1;
         step_pos   = pos_ff + ADDR_W'(1);
         step_col   = (col_ff == LAST_COL) ? '0 : col_ff + COL_W'(1);
      end
      set_wide = WIDE_W'(req_data.new_position);
      idx_wide = WIDE_W'(req_data.cell_index);
      set_pos  = (set_wide >= USED_W) ? LAST_USED_A : set_wide[ADDR_W-1:0];
      idx_ok   = (idx_wide < CELL_COUNT_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         cnt_ff     <= '0;
         pos_ff     <= '0;
         col_ff     <= '0;
         copy_wr_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         pos_ff     <= pos_in;
         col_ff     <= col_in;
         copy_wr_ff <= copy_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      attr_ff  <= attr_in;
      rd_ok_ff <= rd_ok_in;
   end

   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      pos_in            = pos_ff;
      col_in            = col_ff;
      attr_in           = attr_ff;
      rd_ok_in          = rd_ok_ff;
      copy_wr_in        = 1'b0;
      req_ready         = 1'b0;
      done              = 1'b0;
      result.cursor_now = CURSOR_W'(pos_ff);
      result.cell_word  = '0;
      wr_en             = 1'b0;
      wr_addr           = pos_ff;
      wr_data           = '0;
      rd_en             = 1'b0;
      rd_addr           = cnt_ff;

      case (state_ff)
         ST_INIT: begin
            // Clearing sweep over the whole memory after reset.
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            if (cnt_ff == LAST_CELL_A) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_data.action)
                  ACT_WRITE: begin
                     attr_in = req_attr;
                     if (plain_char) begin
                        wr_en   = 1'b1;
                        wr_addr = pos_ff;
                        wr_data = {req_attr, req_data.char_code[7:0]};
                     end
                     if (step_pos == USED_A) begin
                        pos_in   = SCROLL_A;
                        col_in   = '0;
                        cnt_in   = COLUMNS_A;
                        state_in = ST_COPY;
                     end else begin
                        pos_in   = step_pos;
                        col_in   = step_col;
                        state_in = ST_SPACE;
                     end
                  end
                  ACT_SET: begin
                     pos_in   = set_pos;
                     cnt_in   = set_pos;
                     state_in = ST_DIVIDE;
                  end
                  ACT_READ: begin
                     rd_ok_in = idx_ok;
                     rd_en    = idx_ok;
                     rd_addr  = idx_wide[ADDR_W-1:0];
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_REPORT;
                  end
               endcase
            end
         end

         ST_SPACE: begin
            // The space write repeats harmlessly while the result waits.
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = {attr_ff, CHAR_SPACE};
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_COPY: begin
            // Read one row ahead; each write follows in the cycle after its read.
            if (cnt_ff != USED_A) begin
               rd_en      = 1'b1;
               rd_addr    = cnt_ff;
               copy_wr_in = 1'b1;
               cnt_in     = cnt_ff + ADDR_W'(1);
            end else begin
               cnt_in   = SCROLL_A;
               state_in = ST_CLEAR;
            end
            if (copy_wr_ff) begin
               wr_en   = 1'b1;
               wr_addr = cnt_ff - COPY_BACK_A;
               wr_data = rd_data;
            end
         end

         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            if (cnt_ff == LAST_USED_A) begin
               state_in = ST_SPACE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end

         ST_DIVIDE: begin
            // Column of the new cursor by repeated row subtraction.
            if (cnt_ff < COLUMNS_A) begin
               col_in   = COL_W'(cnt_ff);
               state_in = ST_REPORT;
            end else begin
               cnt_in = cnt_ff - COLUMNS_A;
            end
         end

         ST_READ: begin
            result.cell_word = rd_ok_ff ? rd_data : '0;
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_REPORT: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
